// ===== rtl/hrcf_pkg.sv =====
// ----------------------------------------------------------------------------
// hrcf_pkg
// Shared types, constants and helpers for the HTTP request completeness framer.
// ----------------------------------------------------------------------------
package hrcf_pkg;

    // Width of the byte counter, body start and length value
    localparam int COUNT_BITS      = 32;
    localparam int WIDE_BITS       = COUNT_BITS + 4;
    localparam int OFFSET_BITS     = 32;
    localparam int MARKER_LEN      = 15;
    localparam int MARKER_IDX_BITS = 4;

    typedef logic [COUNT_BITS-1:0]      t_count;
    typedef logic [MARKER_IDX_BITS-1:0] t_marker_idx;
    typedef logic [OFFSET_BITS-1:0]     t_offset;

    localparam t_count      COUNT_MAX  = '1;
    localparam t_marker_idx MARKER_END = MARKER_IDX_BITS'(MARKER_LEN);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_C  = 8'h43;

    // Content-Length value parse phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SKIP    = 3'd1,
        PH_SIGN    = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_STOPPED = 3'd4,
        PH_CLOSED  = 3'd5
    } t_len_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_NEED_MORE = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    // Header scanner to length parser
    typedef struct packed {
        logic active;      // headers not yet ended
        logic marker_hit;  // this byte completes the marker
    } t_scan_ctrl;

    // Header scanner next state, seen by the top level
    typedef struct packed {
        logic   header_ended;
        t_count byte_count;
        t_count body_start;
    } t_scan_status;

    // Length parser next state, seen by the top level
    typedef struct packed {
        t_len_phase phase;
        t_count     value;
        logic       error;
    } t_len_status;

    // "Content-Length:" one character per index
    function automatic logic [7:0] marker_char(input t_marker_idx idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Whitespace skipped ahead of the length value
    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
               (b == CH_LF) || (b == CH_VT) || (b == CH_FF);
    endfunction

    // Low 32 bits of a count, zero-extended when the count is narrower
    function automatic t_offset to_offset(input t_count x);
        logic [63:0] w;
        w = 64'(x);
        return w[OFFSET_BITS-1:0];
    endfunction

endpackage

// ===== rtl/hrcf_req_if.sv =====
// ----------------------------------------------------------------------------
// hrcf_req_if
// Request channel: one received byte with its start-of-buffer flag.
// ----------------------------------------------------------------------------
interface hrcf_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_buffer;

    modport source (output valid, output data_byte, output start_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input start_of_buffer, output ready);
endinterface

// ===== rtl/hrcf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hrcf_rsp_if
// Response channel: completeness status, body offset and header-end flag.
// ----------------------------------------------------------------------------
interface hrcf_rsp_if
    import hrcf_pkg::*;
;
    logic    valid;
    logic    ready;
    logic [1:0] status;
    t_offset body_offset;
    logic    headers_done;

    modport source (output valid, output status, output body_offset, output headers_done,
                    input ready);
    modport sink   (input valid, input status, input body_offset, input headers_done,
                    output ready);
endinterface

// ===== rtl/hrcf_header_scan.sv =====
// ----------------------------------------------------------------------------
// hrcf_header_scan
// Byte counter, CR LF CR LF header-end matcher and Content-Length marker match.
// ----------------------------------------------------------------------------
module hrcf_header_scan
    import hrcf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic [7:0]   i_data_byte,
    input  logic         i_sob,
    input  logic         i_phase_idle,
    output t_scan_ctrl   o_ctrl,
    output t_scan_status o_stat
);

    logic        r_header_ended, n_header_ended;
    t_count      r_byte_count,   n_byte_count;
    t_count      r_body_start,   n_body_start;
    logic [1:0]  r_blank,        n_blank;
    t_marker_idx r_marker,       n_marker;

    t_count      cur_count;
    t_count      cur_start;
    logic        cur_ended;
    logic [1:0]  cur_blank;
    t_marker_idx cur_marker;
    logic        is_cr;
    logic        is_lf;

    // Next state; start of buffer clears state ahead of this byte
    always_comb begin
        cur_count  = i_sob ? '0 : r_byte_count;
        cur_start  = i_sob ? '0 : r_body_start;
        cur_ended  = i_sob ? 1'b0 : r_header_ended;
        cur_blank  = i_sob ? 2'd0 : r_blank;
        cur_marker = i_sob ? '0 : r_marker;
        is_cr      = (i_data_byte == CH_CR);
        is_lf      = (i_data_byte == CH_LF);

        n_byte_count   = (cur_count == COUNT_MAX) ? cur_count : cur_count + t_count'(1);
        n_body_start   = cur_start;
        n_header_ended = cur_ended;
        n_blank        = cur_blank;
        n_marker       = cur_marker;

        if (!cur_ended) begin
            // marker search, only while no marker has been found
            if (i_phase_idle) begin
                if (cur_marker < MARKER_END && i_data_byte == marker_char(cur_marker))
                    n_marker = cur_marker + t_marker_idx'(1);
                else
                    n_marker = (i_data_byte == CH_UC_C) ? t_marker_idx'(1) : '0;
            end

            // blank line matcher
            case (cur_blank) inside
                2'd0, 2'd2: n_blank = is_cr ? cur_blank + 2'd1 : 2'd0;
                2'd1:       n_blank = is_lf ? 2'd2 : (is_cr ? 2'd1 : 2'd0);
                default: begin
                    if (is_lf) begin
                        n_header_ended = 1'b1;
                        n_body_start   = n_byte_count;
                        n_blank        = 2'd0;
                    end else begin
                        n_blank = is_cr ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end

        o_ctrl.active       = !cur_ended;
        o_ctrl.marker_hit   = !cur_ended && i_phase_idle && (n_marker == MARKER_END);
        o_stat.header_ended = n_header_ended;
        o_stat.byte_count   = n_byte_count;
        o_stat.body_start   = n_body_start;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_ended <= 1'b0;
            r_byte_count   <= '0;
            r_body_start   <= '0;
            r_blank        <= 2'd0;
            r_marker       <= '0;
        end else if (i_step) begin
            r_header_ended <= n_header_ended;
            r_byte_count   <= n_byte_count;
            r_body_start   <= n_body_start;
            r_blank        <= n_blank;
            r_marker       <= n_marker;
        end
    end

    // Body start is a real offset within the bytes counted so far
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_ended |-> (r_body_start != '0) && (r_byte_count >= r_body_start))
    else $error("body start outside counted bytes");

endmodule

// ===== rtl/hrcf_length_parse.sv =====
// ----------------------------------------------------------------------------
// hrcf_length_parse
// Parses the Content-Length value: whitespace, optional plus, decimal digits.
// ----------------------------------------------------------------------------
module hrcf_length_parse
    import hrcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_sob,
    input  t_scan_ctrl  i_ctrl,
    output logic        o_phase_idle,
    output t_len_status o_stat
);

    t_len_phase r_phase, n_phase;
    t_count     r_value, n_value;
    logic       r_error, n_error;
    logic       r_prev_cr, n_prev_cr;

    t_len_phase         cur_phase;
    t_count             cur_value;
    logic               cur_error;
    logic               cur_prev_cr;
    logic               is_digit;
    logic [3:0]         digit;
    logic [WIDE_BITS-1:0] acc;
    logic               ovf;

    // Current state after an optional start-of-buffer clear
    always_comb begin
        cur_phase    = i_sob ? PH_IDLE : r_phase;
        cur_value    = i_sob ? '0 : r_value;
        cur_error    = i_sob ? 1'b0 : r_error;
        cur_prev_cr  = i_sob ? 1'b0 : r_prev_cr;
        o_phase_idle = (cur_phase == PH_IDLE);
    end

    // value * 10 + digit, overflow when it spills past the count width
    always_comb begin
        logic [7:0] diff;
        is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        diff     = i_data_byte - CH_ZERO;
        digit    = is_digit ? diff[3:0] : 4'd0;
        acc      = (WIDE_BITS'(cur_value) << 3) + (WIDE_BITS'(cur_value) << 1)
                 + WIDE_BITS'(digit);
        ovf      = |acc[WIDE_BITS-1:COUNT_BITS];
    end

    // Phase sequencing
    always_comb begin
        n_phase   = cur_phase;
        n_value   = cur_value;
        n_error   = cur_error;
        n_prev_cr = (i_data_byte == CH_CR);

        if (i_ctrl.active) begin
            if (cur_phase == PH_IDLE) begin
                if (i_ctrl.marker_hit)
                    n_phase = PH_SKIP;
            end else if (cur_phase != PH_CLOSED) begin
                if (i_data_byte == CH_LF && cur_prev_cr) begin
                    // CR LF closes the value line
                    if (cur_phase == PH_SKIP || cur_phase == PH_SIGN)
                        n_error = 1'b1;
                    n_phase = PH_CLOSED;
                end else begin
                    unique case (cur_phase)
                        PH_SKIP: begin
                            if (is_space(i_data_byte)) begin
                                n_phase = PH_SKIP;
                            end else if (i_data_byte == CH_PLUS) begin
                                n_phase = PH_SIGN;
                            end else if (is_digit) begin
                                n_value = t_count'(digit);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_error = 1'b1;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_SIGN: begin
                            if (is_digit) begin
                                n_value = t_count'(digit);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_error = 1'b1;
                                n_phase = PH_STOPPED;
                            end
                        end
                        PH_DIGITS: begin
                            if (!is_digit) begin
                                n_phase = PH_STOPPED;
                            end else if (ovf) begin
                                n_error = 1'b1;
                                n_phase = PH_STOPPED;
                            end else begin
                                n_value = acc[COUNT_BITS-1:0];
                            end
                        end
                        default: n_phase = cur_phase;
                    endcase
                end
            end
        end

        o_stat.phase = n_phase;
        o_stat.value = n_value;
        o_stat.error = n_error;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_value   <= '0;
            r_error   <= 1'b0;
            r_prev_cr <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_value   <= n_value;
            r_error   <= n_error;
            r_prev_cr <= n_prev_cr;
        end
    end

    // An error always ends value parsing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |-> (r_phase == PH_STOPPED) || (r_phase == PH_CLOSED))
    else $error("length error with value parse still running");

endmodule

// ===== rtl/http_request_completeness_framer_core.sv =====
// ----------------------------------------------------------------------------
// http_request_completeness_framer_core
// Per-byte HTTP/1.1 message framing by header end and Content-Length.
// ----------------------------------------------------------------------------
// Feed the request buffer one byte per request, raising start_of_buffer on
// the first byte of a new buffer; every byte yields exactly one response
// telling whether the bytes so far form a complete message (status 1), need
// more data (0) or carry a malformed Content-Length (2, reported only once
// headers_done is set), plus the body offset after the blank line. The block
// takes one byte every clock while responses are taken: the parse update
// for a byte is combinational from the parse state registers, a new byte
// gets in only while the response register is empty or being read, and its
// response appears in the cycle after the byte is accepted.
module http_request_completeness_framer_core
    import hrcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrcf_req_if.sink    i_req,
    hrcf_rsp_if.source  o_rsp
);

    logic         step;
    logic         phase_idle;
    t_scan_ctrl   scan_ctrl;
    t_scan_status scan_stat;
    t_len_status  len_stat;
    t_count       body_len;
    t_status      n_status;
    t_offset      n_offset;

    logic         r_out_valid;
    t_status      r_status;
    t_offset      r_body_offset;
    logic         r_headers_done;

    // Request handshake: accept while the response slot is free or draining
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign step        = i_req.valid && i_req.ready;

    hrcf_header_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (i_req.data_byte),
        .i_sob        (i_req.start_of_buffer),
        .i_phase_idle (phase_idle),
        .o_ctrl       (scan_ctrl),
        .o_stat       (scan_stat)
    );

    hrcf_length_parse u_len (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (i_req.data_byte),
        .i_sob        (i_req.start_of_buffer),
        .i_ctrl       (scan_ctrl),
        .o_phase_idle (phase_idle),
        .o_stat       (len_stat)
    );

    // Completeness decision from the updated parse state
    always_comb begin
        body_len = scan_stat.byte_count - scan_stat.body_start;
        n_status = ST_NEED_MORE;
        if (scan_stat.header_ended) begin
            if (len_stat.phase == PH_IDLE)
                n_status = ST_COMPLETE;
            else if (len_stat.error)
                n_status = ST_MALFORMED;
            else if (body_len >= len_stat.value)
                n_status = ST_COMPLETE;
        end
        n_offset = scan_stat.header_ended ? to_offset(scan_stat.body_start) : '0;
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status       <= n_status;
            r_body_offset  <= n_offset;
            r_headers_done <= scan_stat.header_ended;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.body_offset  = r_body_offset;
    assign o_rsp.headers_done = r_headers_done;

    // Malformed length is only reported after the headers ended
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_MALFORMED) |-> o_rsp.headers_done)
    else $error("malformed status before header end");

    // Before header end nothing is complete and the offset reads zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.headers_done |->
            (o_rsp.status == ST_NEED_MORE) && (o_rsp.body_offset == '0))
    else $error("response fields set before header end");

    // Every accepted byte produces a pending response on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_rsp.valid)
    else $error("accepted byte without response");

endmodule

// ===== bench/tb_http_request_completeness_framer_core.sv =====
// ----------------------------------------------------------------------------
// tb_http_request_completeness_framer_core
// Self-checking bench for the per-byte HTTP message framer. A short table of
// bytes with hand-typed results comes first; then generated requests, mostly
// well-formed headers with a random Content-Length value and random body
// bytes, mixed with noise and cut-off requests. Every response is checked
// against an in-bench model of the framing state, with random idling on both
// channels and a long response stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb_http_request_completeness_framer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hrcf_pkg::*;

    localparam int  HOLD_CYCLES = 120;
    localparam int  PHASE_BYTES = 450;
    localparam int  MAX_REPORTS = 10;
    localparam logic [MARKER_LEN*8-1:0] LEN_MARKER = "Content-Length:";

    typedef logic [WIDE_BITS-1:0] t_wide;

    // One response as seen on the output channel
    typedef struct packed {
        t_status st;
        t_offset off;
        logic    hd;
    } t_frame_res;

    // Directed table row: a string, or one raw byte when the string is empty
    typedef struct {
        string      text;
        logic [7:0] raw;
        logic       sob;
        logic       pinned;
        t_frame_res res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    hrcf_req_if req_ch ();
    hrcf_rsp_if rsp_ch ();

    http_request_completeness_framer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Model state of the framer
    t_count      seen_bytes;
    logic [1:0]  blank_stage;
    logic        hdr_closed;
    t_marker_idx mark_hits;
    t_len_phase  len_ph;
    t_count      len_val;
    t_count      body_at;
    logic        len_bad;
    logic        last_cr;

    t_frame_res  framing_due[$];
    int          fault_cnt;

    // Typed result travelling with a directed byte
    logic        pin_on;
    t_frame_res  pin_res;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_pending;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("** http_request_completeness_framer_core: FAILED **");
        $finish;
    end

    function automatic void clear_frame_state();
        seen_bytes  = '0;
        blank_stage = '0;
        hdr_closed  = 1'b0;
        mark_hits   = '0;
        len_ph      = PH_IDLE;
        len_val     = '0;
        body_at     = '0;
        len_bad     = 1'b0;
        last_cr     = 1'b0;
    endfunction

    function automatic logic ws_char(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
               (b == CH_LF) || (b == CH_VT) || (b == CH_FF);
    endfunction

    // Content-Length value: whitespace, optional plus, digits, CR LF close
    function automatic void parse_value_byte(input logic [7:0] b);
        logic       digit;
        logic [3:0] d;
        t_wide      grown;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        d     = digit ? 4'(b - CH_ZERO) : 4'd0;
        if (b == CH_LF && last_cr) begin
            if (len_ph == PH_SKIP || len_ph == PH_SIGN) len_bad = 1'b1;
            len_ph = PH_CLOSED;
        end else begin
            case (len_ph)
                PH_SKIP: begin
                    if (b == CH_PLUS) begin
                        len_ph = PH_SIGN;
                    end else if (digit) begin
                        len_val = t_count'(d);
                        len_ph  = PH_DIGITS;
                    end else if (!ws_char(b)) begin
                        len_bad = 1'b1;
                        len_ph  = PH_STOPPED;
                    end
                end
                PH_SIGN: begin
                    if (digit) begin
                        len_val = t_count'(d);
                        len_ph  = PH_DIGITS;
                    end else begin
                        len_bad = 1'b1;
                        len_ph  = PH_STOPPED;
                    end
                end
                PH_DIGITS: begin
                    if (digit) begin
                        grown = t_wide'(len_val) * t_wide'(10) + t_wide'(d);
                        if (grown > t_wide'(COUNT_MAX)) begin
                            len_bad = 1'b1;
                            len_ph  = PH_STOPPED;
                        end else begin
                            len_val = t_count'(grown);
                        end
                    end else begin
                        len_ph = PH_STOPPED;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // Advance the model by one byte and return the response it calls for
    function automatic t_frame_res predict_framing(input logic [7:0] b, input logic sob);
        t_frame_res r;
        if (sob) clear_frame_state();
        if (seen_bytes != COUNT_MAX) seen_bytes++;

        if (!hdr_closed) begin
            if (len_ph >= PH_SKIP && len_ph <= PH_STOPPED) begin
                parse_value_byte(b);
            end else if (len_ph == PH_IDLE) begin
                if (mark_hits < MARKER_END &&
                    b == LEN_MARKER[(MARKER_LEN-1-int'(mark_hits))*8 +: 8])
                    mark_hits++;
                else
                    mark_hits = (b == CH_UC_C) ? t_marker_idx'(1) : '0;
                if (mark_hits == MARKER_END) len_ph = PH_SKIP;
            end

            // blank line matcher
            case (blank_stage)
                2'd0, 2'd2: blank_stage = (b == CH_CR) ? blank_stage + 2'd1 : 2'd0;
                2'd1: blank_stage = (b == CH_LF) ? 2'd2 : ((b == CH_CR) ? 2'd1 : 2'd0);
                default: begin
                    if (b == CH_LF) begin
                        hdr_closed  = 1'b1;
                        body_at     = seen_bytes;
                        blank_stage = 2'd0;
                    end else begin
                        blank_stage = (b == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end
        last_cr = (b == CH_CR);

        r.st = ST_NEED_MORE;
        if (hdr_closed) begin
            if (len_ph == PH_IDLE)
                r.st = ST_COMPLETE;
            else if (len_bad)
                r.st = ST_MALFORMED;
            else if (t_count'(seen_bytes - body_at) >= len_val)
                r.st = ST_COMPLETE;
        end
        r.off = hdr_closed ? t_offset'(body_at) : '0;
        r.hd  = hdr_closed;
        return r;
    endfunction

    function automatic void log_fault(input string what, input t_frame_res e);
        if (fault_cnt < MAX_REPORTS)
            $display("%0t %s: exp st=%0d off=%0d hd=%0b, got st=%0d off=%0d hd=%0b",
                     $realtime, what, e.st, e.off, e.hd,
                     rsp_ch.status, rsp_ch.body_offset, rsp_ch.headers_done);
        fault_cnt++;
    endfunction

    // Response checking and request prediction
    always @(posedge i_clk) begin : frame_check
        t_frame_res want_res;
        t_frame_res calc;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (framing_due.size() == 0) begin
                    log_fault("response with nothing pending", '0);
                end else begin
                    want_res = framing_due.pop_front();
                    if (rsp_ch.status !== want_res.st ||
                        rsp_ch.body_offset !== want_res.off ||
                        rsp_ch.headers_done !== want_res.hd)
                        log_fault("response mismatch", want_res);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                calc = predict_framing(req_ch.data_byte, req_ch.start_of_buffer);
                framing_due.push_back(pin_on ? pin_res : calc);
            end
        end
    end

    // Response side ready: random idling plus the occasional long hold-off
    initial begin : rsp_side
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte, return at the falling edge after it is taken
    task automatic send_byte(input logic [7:0] b, input logic sob, input logic pin,
                             input t_frame_res pres);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.data_byte       <= b;
        req_ch.start_of_buffer <= sob;
        pin_on                 <= pin;
        pin_res                <= pres;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic append_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endtask

    // Filler lines of printable text, each closed by CR LF; sometimes none
    task automatic append_junk(ref logic [7:0] q[$]);
        case ($urandom_range(5))
            0: append_text(q, "Host: a\015\012");
            1: append_text(q, "content-length: 7\015\012");
            2: append_text(q, "Content-Len\015\012");
            3: append_text(q, "CContent-Type: x\015\012");
            4: begin
                repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(32, 126)));
                append_text(q, "\015\012");
            end
            default: ;
        endcase
    endtask

    // Generated request: headers, optional length line, blank line, body
    task automatic build_request(ref logic [7:0] q[$]);
        int unsigned     body_len;
        int unsigned     cut;
        int unsigned     want;
        logic            exact;
        logic            has_len;
        q.delete();
        if ($urandom_range(99) < 6) begin
            // plain noise
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
        end else begin
            if ($urandom_range(1)) append_text(q, "GET / HTTP/1.1\015\012");
            append_junk(q);
            has_len = ($urandom_range(99) < 80);
            want    = 0;
            exact   = 1'b0;
            if (has_len) begin
                append_text(q, "Content-Length:");
                if ($urandom_range(2) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(5))
                            0: q.push_back(CH_SPACE);
                            1: q.push_back(CH_TAB);
                            2: q.push_back(CH_VT);
                            3: q.push_back(CH_FF);
                            4: q.push_back(CH_LF);
                            default: append_text(q, "\015 ");
                        endcase
                    end
                end
                want = $urandom_range(0, 24);
                case ($urandom_range(9))
                    0, 1, 2: begin
                        append_text(q, $sformatf("%0d", want));
                        exact = 1'b1;
                    end
                    3: begin
                        append_text(q, $sformatf("+%0d", want));
                        exact = 1'b1;
                    end
                    4: append_text(q, $sformatf("-%0d", want));
                    5: ;   // no value at all
                    6: append_text(q, $urandom_range(1) ? "+x" : "abc");
                    7: begin
                        // too wide for the count
                        if ($urandom_range(1)) begin
                            append_text(q, "4294967296");
                        end else begin
                            q.push_back(8'($urandom_range(CH_ZERO + 1, CH_NINE)));
                            repeat ($urandom_range(10, 13))
                                q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                        end
                    end
                    8: begin
                        if ($urandom_range(1)) begin
                            append_text(q, "4294967295");
                        end else begin
                            append_text(q, $sformatf("000%0d", want));
                            exact = 1'b1;
                        end
                    end
                    default: begin
                        append_text(q, $sformatf("%0d ;v=1", want));
                        exact = 1'b1;
                    end
                endcase
                append_text(q, "\015\012");
                if ($urandom_range(4) == 0) append_text(q, "Content-Length: 99\015\012");
            end
            append_junk(q);
            append_text(q, "\015\012");

            // a length line in the body does not count
            if (!has_len && $urandom_range(2) == 0) append_text(q, "Content-Length: 3\015\012");
            if (exact) begin
                body_len = want + $urandom_range(0, 3);
                if ($urandom_range(3) == 0 && want > 0) body_len = want - 1;
            end else begin
                body_len = $urandom_range(0, 4);
            end
            repeat (body_len) q.push_back(8'($urandom));

            // cut-off request
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(1, q.size());
                while (q.size() > cut) void'(q.pop_back());
            end
        end
    endtask

    // Stimulus
    initial begin : stim
        t_dir_row   dir_tab[$];
        t_dir_row   row;
        logic [7:0] req_bytes[$];
        logic       sob;
        int         sent;
        logic       last;

        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.data_byte       = '0;
        req_ch.start_of_buffer = 1'b0;
        pin_on                 = 1'b0;
        pin_res                = '0;
        send_idle_pct          = 11;
        recv_idle_pct          = 58;
        hold_pending           = 1'b0;
        fault_cnt              = 0;
        clear_frame_state();

        // directed: byte extremes, no start flag after reset, a minus sign
        // that is reported once the headers end, header end with no length
        row = '{"", 8'h00, 1'b0, 1'b1, '{ST_NEED_MORE, 32'd0, 1'b0}};
        dir_tab.push_back(row);
        row = '{"", 8'hFF, 1'b0, 1'b1, '{ST_NEED_MORE, 32'd0, 1'b0}};
        dir_tab.push_back(row);
        row = '{"Content-Length:-\015\012\015\012", 8'h00, 1'b1, 1'b1,
                '{ST_MALFORMED, 32'd20, 1'b1}};
        dir_tab.push_back(row);
        row = '{"", 8'hFF, 1'b1, 1'b1, '{ST_NEED_MORE, 32'd0, 1'b0}};
        dir_tab.push_back(row);
        row = '{"\015\012\015\012", 8'h00, 1'b0, 1'b1, '{ST_COMPLETE, 32'd5, 1'b1}};
        dir_tab.push_back(row);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r]) begin
            req_bytes.delete();
            if (dir_tab[r].text.len() == 0)
                req_bytes.push_back(dir_tab[r].raw);
            else
                append_text(req_bytes, dir_tab[r].text);
            foreach (req_bytes[i]) begin
                last = (i == req_bytes.size() - 1);
                send_byte(req_bytes[i], (i == 0) && dir_tab[r].sob,
                          last && dir_tab[r].pinned, dir_tab[r].res);
            end
        end

        // random requests in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 11; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph != 1) hold_pending = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_request(req_bytes);
                sob = ($urandom_range(9) != 0);
                foreach (req_bytes[i]) begin
                    send_byte(req_bytes[i], (i == 0) && sob, 1'b0, '0);
                    sent++;
                end
            end
        end
        req_ch.valid <= 1'b0;

        // drain
        while (framing_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        fault_cnt += framing_due.size();

        if (fault_cnt == 0) begin
            $display("** http_request_completeness_framer_core: PASSED **");
        end else begin
            $display("** http_request_completeness_framer_core: FAILED **");
        end
        $finish;
    end

endmodule
